// ===== rtl/core/dsn_pkg.sv =====
// ----------------------------------------------------------------------------
// dsn_pkg
// Shared types, codes and helpers for the diamond-square noise map core.
// ----------------------------------------------------------------------------
`default_nettype none

package dsn_pkg;

   localparam int MAX_SIZE_LOG2 = 8;
   localparam int COORD_W       = MAX_SIZE_LOG2;
   localparam int ADDR_W        = 2 * MAX_SIZE_LOG2;
   localparam int MAP_WORDS     = 1 << ADDR_W;
   localparam int HEIGHT_W      = 15;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_RAND  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0] ST_MORE    = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_READ    = 2'd2;
   localparam logic [1:0] ST_REFUSED = 2'd3;

   localparam logic [3:0] SIZE_LOG2_RESET = 4'd8;
   localparam logic [14:0] AMP_RESET      = 15'h7FFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [14:0] random_value;
      logic [15:0] pixel_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] pixel_byte;
   } rsp_type;

   // row-major address of a wrapped map position
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [3:0] gl);
      logic [COORD_W:0]   side;
      logic [COORD_W-1:0] m;
      side = (COORD_W+1)'(1) << gl;
      m    = COORD_W'(side - (COORD_W+1)'(1));
      return (ADDR_W'(y & m) << gl) | ADDR_W'(x & m);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/diamond_square_noise_map_core.sv =====
// ----------------------------------------------------------------------------
// diamond_square_noise_map_core
// Wrap-around diamond-square height map generator with normalized readout.
// ----------------------------------------------------------------------------
// One request at a time, one response each. The map sits in a single-port
// RAM, so its accesses are serialized. A start clears the corner, then
// averages each point with 4 neighbor reads and a write over three sweeps.
// A random word reads and rewrites its cell. When it closes a level, the
// next level's averaging follows. When it closes the last level, a peak
// scan over the map follows. A read fetches its cell, then runs a bit-serial
// division when the peak is nonzero. A refused request goes straight to the
// response register. Every response passes through the response register;
// a stalled response holds the block there until it is taken.
`default_nettype none

module diamond_square_noise_map_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire dsn_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output dsn_pkg::rsp_type     rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [3:0]      csr_data
);

   import dsn_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_START_WR, S_PASS_RD, S_PASS_WR, S_RND_RD, S_RND_WR,
      S_PEAK, S_RD_RD, S_RD_DATA, S_DIV, S_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      P_DIAMOND, P_SQUARE_A, P_SQUARE_B
   } pass_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_GEN, PH_DONE
   } phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   pass_type              pass_ff, pass_in;
   logic [3:0]            size_ff, size_in;
   logic [3:0]            gl_ff, gl_in;
   logic [COORD_W-1:0]    half_ff, half_in;
   logic [14:0]           amp_ff, amp_in;
   logic [COORD_W:0]      sx_ff, sx_in, sy_ff, sy_in;
   logic [COORD_W:0]      px_ff, px_in, py_ff, py_in, g2_ff, g2_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [16:0]           sum_ff, sum_in;
   logic [14:0]           peak_ff, peak_in;
   logic [ADDR_W:0]       pk_ff, pk_in;
   logic [14:0]           rem_ff, rem_in;
   logic [7:0]            lo_ff, lo_in;
   logic [2:0]            dcnt_ff, dcnt_in;
   req_type               item_ff, item_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_addr;
   logic [HEIGHT_W-1:0]   mem_wdata, mem_rdata;

   dsn_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAP_WORDS)) u_map (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   logic [COORD_W:0]   side;
   logic [ADDR_W:0]    area;
   logic [COORD_W-1:0] x, y, g, g2;
   logic [COORD_W-1:0] nx, ny, tx, ty;
   logic [ADDR_W-1:0]  rnd_addr;
   logic [16:0]        total;
   logic [COORD_W:0]   adv_x, adv_y, scan_nx, scan_ny;
   logic [3:0]         clamp;
   logic [22:0]        prod;
   logic [15:0]        trial;
   logic               ge;

   assign side      = (COORD_W+1)'(1) << gl_ff;
   assign area      = (ADDR_W+1)'(1) << {gl_ff, 1'b0};
   assign x         = px_ff[COORD_W-1:0];
   assign y         = py_ff[COORD_W-1:0];
   assign g2        = g2_ff[COORD_W-1:0];
   assign g         = g2_ff[COORD_W:1];
   assign total     = sum_ff + 17'(mem_rdata);
   assign adv_x     = px_ff + g2_ff;
   assign adv_y     = py_ff + g2_ff;
   assign scan_nx   = sx_ff + (COORD_W+1)'(half_ff);
   assign scan_ny   = sy_ff + (COORD_W+1)'(half_ff);
   assign rnd_addr  = cell_addr(sx_ff[COORD_W-1:0], sy_ff[COORD_W-1:0], gl_ff);
   assign prod      = {mem_rdata, 8'd0} - 23'(mem_rdata);
   assign trial     = {rem_ff, lo_ff[7]};
   assign ge        = trial >= {1'b0, peak_ff};
   assign clamp     = (size_ff == 4'd0) ? 4'd1 :
                      (size_ff > 4'(MAX_SIZE_LOG2)) ? 4'(MAX_SIZE_LOG2) : size_ff;

   // neighbor and target positions of the point being averaged
   always_comb begin
      nx = x;
      ny = y;
      tx = x;
      ty = y;
      case (pass_ff)
         P_DIAMOND: begin
            tx = x + g;
            ty = y + g;
            case (cnt_ff)
               2'd0: begin nx = x;      ny = y;      end
               2'd1: begin nx = x + g2; ny = y;      end
               2'd2: begin nx = x;      ny = y + g2; end
               default: begin nx = x + g2; ny = y + g2; end
            endcase
         end
         P_SQUARE_A: begin
            tx = x + g;
            case (cnt_ff)
               2'd0: begin nx = x;      ny = y;      end
               2'd1: begin nx = x + g2; ny = y;      end
               2'd2: begin nx = x + g;  ny = y - g;  end
               default: begin nx = x + g; ny = y + g; end
            endcase
         end
         default: begin
            ty = y + g;
            case (cnt_ff)
               2'd0: begin nx = x;      ny = y;      end
               2'd1: begin nx = x;      ny = y + g2; end
               2'd2: begin nx = x - g;  ny = y + g;  end
               default: begin nx = x + g; ny = y + g; end
            endcase
         end
      endcase
   end

   // map port
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = '0;
      mem_wdata = '0;
      unique case (state_ff)
         S_START_WR: begin
            mem_we = 1'b1;
         end
         S_PASS_RD: begin
            mem_addr = cell_addr(nx, ny, gl_ff);
         end
         S_PASS_WR: begin
            mem_we    = 1'b1;
            mem_addr  = cell_addr(tx, ty, gl_ff);
            mem_wdata = total[16:2];
         end
         S_RND_RD: begin
            mem_addr = rnd_addr;
         end
         S_RND_WR: begin
            mem_we    = 1'b1;
            mem_addr  = rnd_addr;
            mem_wdata = mem_rdata + (item_ff.random_value & amp_ff);
         end
         S_PEAK: begin
            mem_addr = pk_ff[ADDR_W-1:0];
         end
         S_RD_RD: begin
            mem_addr = item_ff.pixel_index & ADDR_W'(area - (ADDR_W+1)'(1));
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pass_in      = pass_ff;
      size_in      = size_ff;
      gl_in        = gl_ff;
      half_in      = half_ff;
      amp_in       = amp_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      g2_in        = g2_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      pk_in        = pk_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      dcnt_in      = dcnt_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_valid) begin
         size_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               res_in  = '{status: ST_REFUSED, pixel_byte: 8'd0};
               state_in = S_RESPOND;
               case (req_data.action)
                  ACT_START: begin
                     gl_in    = clamp;
                     state_in = S_START_WR;
                  end
                  ACT_RAND: begin
                     if (phase_ff == PH_GEN && half_ff != '0) begin
                        state_in = S_RND_RD;
                     end
                  end
                  ACT_READ: begin
                     if (phase_ff == PH_DONE) begin
                        state_in = S_RD_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_START_WR: begin
            half_in  = side[COORD_W:1];
            amp_in   = AMP_RESET >> 1;
            sx_in    = '0;
            sy_in    = '0;
            peak_in  = '0;
            phase_in = PH_GEN;
            g2_in    = side;
            px_in    = '0;
            py_in    = '0;
            pass_in  = P_DIAMOND;
            cnt_in   = '0;
            res_in   = '{status: ST_MORE, pixel_byte: 8'd0};
            state_in = S_PASS_RD;
         end
         S_PASS_RD: begin
            sum_in = (cnt_ff == 2'd0) ? 17'd0 : total;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = S_PASS_WR;
            end
         end
         S_PASS_WR: begin
            cnt_in   = '0;
            state_in = S_PASS_RD;
            if (adv_x >= side) begin
               px_in = '0;
               if (adv_y >= side) begin
                  py_in = '0;
                  unique case (pass_ff)
                     P_DIAMOND:  pass_in = P_SQUARE_A;
                     P_SQUARE_A: pass_in = P_SQUARE_B;
                     default:    state_in = S_RESPOND;
                  endcase
               end else begin
                  py_in = adv_y;
               end
            end else begin
               px_in = adv_x;
            end
         end
         S_RND_RD: begin
            state_in = S_RND_WR;
         end
         S_RND_WR: begin
            res_in   = '{status: ST_MORE, pixel_byte: 8'd0};
            state_in = S_RESPOND;
            sx_in    = scan_nx;
            if (scan_nx >= side) begin
               sx_in = '0;
               sy_in = scan_ny;
               if (scan_ny >= side) begin
                  sy_in   = '0;
                  half_in = half_ff >> 1;
                  if (half_ff > COORD_W'(1)) begin
                     amp_in   = amp_ff >> 1;
                     g2_in    = (COORD_W+1)'(half_ff);
                     px_in    = '0;
                     py_in    = '0;
                     pass_in  = P_DIAMOND;
                     cnt_in   = '0;
                     state_in = S_PASS_RD;
                  end else begin
                     pk_in    = '0;
                     peak_in  = '0;
                     state_in = S_PEAK;
                  end
               end
            end
         end
         S_PEAK: begin
            // read data arrives in the cycle after its address
            if (pk_ff != '0 && mem_rdata > peak_ff) begin
               peak_in = mem_rdata;
            end
            pk_in = pk_ff + (ADDR_W+1)'(1);
            if (pk_ff == area) begin
               phase_in = PH_DONE;
               res_in   = '{status: ST_DONE, pixel_byte: 8'd0};
               state_in = S_RESPOND;
            end
         end
         S_RD_RD: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            res_in = '{status: ST_READ, pixel_byte: 8'd0};
            rem_in = prod[22:8];
            lo_in  = prod[7:0];
            dcnt_in = '0;
            state_in = (peak_ff == '0) ? S_RESPOND : S_DIV;
         end
         S_DIV: begin
            // restoring division, quotient bits shift in behind the dividend
            rem_in  = ge ? 15'(trial - {1'b0, peak_ff}) : trial[14:0];
            lo_in   = {lo_ff[6:0], ge};
            dcnt_in = dcnt_ff + 3'd1;
            if (dcnt_ff == 3'd7) begin
               res_in.pixel_byte = {lo_ff[6:0], ge};
               state_in = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         size_ff      <= SIZE_LOG2_RESET;
         gl_ff        <= 4'd1;
         half_ff      <= '0;
         amp_ff       <= AMP_RESET;
         sx_ff        <= '0;
         sy_ff        <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         size_ff      <= size_in;
         gl_ff        <= gl_in;
         half_ff      <= half_in;
         amp_ff       <= amp_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff <= pass_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      g2_ff   <= g2_in;
      cnt_ff  <= cnt_in;
      sum_ff  <= sum_in;
      pk_ff   <= pk_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      dcnt_ff <= dcnt_in;
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/core/dsn_ram.sv =====
// ----------------------------------------------------------------------------
// dsn_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsn_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/dsn_checker.sv =====
// ----------------------------------------------------------------------------
// dsn_checker
// Port-level checks for the diamond-square noise map core.
// ----------------------------------------------------------------------------
`default_nettype none

module dsn_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire dsn_pkg::rsp_type rsp_data
);

   import dsn_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed under stall");

   // one request in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   // only a read response carries a byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_READ |-> rsp_data.pixel_byte == 8'd0)
      else $error("nonzero byte on a non-read response");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("outputs not quiet after reset");

endmodule

bind diamond_square_noise_map_core dsn_checker u_dsn_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the diamond-square noise map core: a behavioral
// height map predicts every response, requests stream in bursts and the
// response side stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dsn_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_data = '0;

   diamond_square_noise_map_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // predicted block state
   logic [14:0] hmap [0:MAP_WORDS-1];
   logic [3:0]  size_reg = SIZE_LOG2_RESET;
   int          glog = 1;
   int          hstep = 0;
   int          amp = 32767;
   int          sx = 0, sy = 0;
   int          gen_phase = 0;   // 0 idle, 1 generating, 2 done
   int          peak = 0;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      errors = 0;
   int      gap_left = 0, burst_left = 0;
   logic    req_taken = 1'b0;

   function automatic int wrap_addr(int x, int y);
      int m;
      m = (1 << glog) - 1;
      return ((y & m) << glog) | (x & m);
   endfunction

   function automatic logic [14:0] mean4(int a, int b, int c, int d);
      int s;
      s = hmap[a] + hmap[b] + hmap[c] + hmap[d];
      return 15'(s >> 2);
   endfunction

   task automatic average_level(int g2);
      int side, g;
      side = 1 << glog;
      g = g2 >> 1;
      for (int y = 0; y < side; y += g2)
         for (int x = 0; x < side; x += g2)
            hmap[wrap_addr(x+g, y+g)] = mean4(wrap_addr(x, y), wrap_addr(x+g2, y),
               wrap_addr(x, y+g2), wrap_addr(x+g2, y+g2));
      for (int y = 0; y < side; y += g2)
         for (int x = 0; x < side; x += g2) begin
            hmap[wrap_addr(x+g, y)] = mean4(wrap_addr(x, y), wrap_addr(x+g2, y),
               wrap_addr(x+g, y-g), wrap_addr(x+g, y+g));
            hmap[wrap_addr(x, y+g)] = mean4(wrap_addr(x, y), wrap_addr(x, y+g2),
               wrap_addr(x-g, y+g), wrap_addr(x+g, y+g));
         end
   endtask

   task automatic predict_rsp(req_type r);
      rsp_type o;
      int side, c, g2, n;
      o.status = ST_REFUSED;
      o.pixel_byte = '0;
      if (r.action == ACT_START) begin
         glog = (size_reg < 1) ? 1 : (size_reg > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : size_reg;
         hmap[0] = '0;
         average_level(1 << glog);
         hstep = (1 << glog) >> 1;
         amp = 32767 >> 1;
         sx = 0; sy = 0; peak = 0;
         gen_phase = 1;
         o.status = ST_MORE;
      end else if (r.action == ACT_RAND) begin
         if (gen_phase == 1 && hstep >= 1) begin
            side = 1 << glog;
            c = wrap_addr(sx, sy);
            hmap[c] = 15'(hmap[c] + (r.random_value & amp));
            sx += hstep;
            if (sx >= side) begin
               sx = 0;
               sy += hstep;
            end
            o.status = ST_MORE;
            if (sy >= side) begin
               g2 = hstep;
               sy = 0;
               hstep = g2 >> 1;
               if (hstep >= 1) begin
                  amp >>= 1;
                  average_level(g2);
               end else begin
                  n = 1 << (2 * glog);
                  peak = 0;
                  for (int i = 0; i < n; i++) if (hmap[i] > peak) peak = hmap[i];
                  gen_phase = 2;
                  o.status = ST_DONE;
               end
            end
         end
      end else if (r.action == ACT_READ) begin
         if (gen_phase == 2) begin
            n = 1 << (2 * glog);
            o.pixel_byte = (peak != 0) ? 8'((hmap[r.pixel_index & (n-1)] * 255) / peak) : 8'd0;
            o.status = ST_READ;
         end
      end
      expected_rsps.push_back(o);
   endtask

   function automatic req_type mk(logic [1:0] a, int v, int p);
      req_type r;
      r.action = a;
      r.random_value = 15'(v);
      r.pixel_index = 16'(p);
      return r;
   endfunction

   // driver: bursts with random gaps, a request holds until it is taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predictor runs on accepted requests
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) predict_rsp(req_data);
   end

   // response stall pattern
   int stall_mode = 0;
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %p", rsp_data);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.pixel_byte !== e.pixel_byte) begin
               $error("pixel_byte expected %0d actual %0d", e.pixel_byte, rsp_data.pixel_byte);
               errors++;
            end
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size(int v);
      @(negedge clock);
      csr_data <= 4'(v);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      size_reg = 4'(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one generation with random words, plus noise and reads
   task automatic queue_generation(int lg, int reads);
      int side, words;
      side = 1 << lg;
      words = 0;
      for (int h = side >> 1; h >= 1; h >>= 1) words += (side / h) * (side / h);
      pending_reqs.push_back(mk(ACT_START, $urandom, $urandom));
      for (int i = 0; i < words; i++) begin
         if ($urandom_range(0, 19) == 0)
            pending_reqs.push_back(mk(ACT_READ, $urandom, $urandom));
         if ($urandom_range(0, 39) == 0)
            pending_reqs.push_back(mk(2'd3, $urandom, $urandom));
         pending_reqs.push_back(mk(ACT_RAND, ($urandom_range(0, 3) == 0) ? 32767 : $urandom, 0));
      end
      for (int i = 0; i < reads; i++)
         pending_reqs.push_back(mk(($urandom_range(0, 15) == 0) ? ACT_RAND : ACT_READ,
                                   $urandom, $urandom));
   endtask

   initial begin
      int lg;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: refused ops before start, size 1 run with extremes
      pending_reqs.push_back(mk(ACT_RAND, 32767, 0));
      pending_reqs.push_back(mk(ACT_READ, 0, 65535));
      pending_reqs.push_back(mk(2'd3, 32767, 65535));
      drain();
      write_size(0);   // clamps to 1
      pending_reqs.push_back(mk(ACT_START, 0, 0));
      for (int i = 0; i < 4; i++) pending_reqs.push_back(mk(ACT_RAND, 0, 0));
      pending_reqs.push_back(mk(ACT_READ, 0, 65535));   // zero peak
      pending_reqs.push_back(mk(ACT_RAND, 32767, 0));   // refused after done
      pending_reqs.push_back(mk(ACT_START, 0, 0));
      for (int i = 0; i < 4; i++) pending_reqs.push_back(mk(ACT_RAND, 32767, 0));
      for (int i = 0; i < 4; i++) pending_reqs.push_back(mk(ACT_READ, 0, i + 4));
      pending_reqs.push_back(mk(ACT_START, 0, 0));
      pending_reqs.push_back(mk(ACT_RAND, 21845, 0));
      pending_reqs.push_back(mk(ACT_START, 0, 0));      // restart mid-generation
      drain();

      // largest map: first levels only, then a restart at another size
      write_size(15);  // clamps to 8
      pending_reqs.push_back(mk(ACT_START, 0, 0));
      for (int i = 0; i < 40; i++) pending_reqs.push_back(mk(ACT_RAND, $urandom, 0));
      pending_reqs.push_back(mk(ACT_READ, 0, 0));       // refused while generating
      drain();

      // random part across sizes
      for (int k = 0; k < 12; k++) begin
         lg = $urandom_range(1, 4);
         if (k == 5) write_size(1);
         else write_size(lg);
         queue_generation(size_reg < 1 ? 1 : size_reg, $urandom_range(20, 50));
         drain();
      end
      write_size(SIZE_LOG2_RESET);
      drain();

      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   initial begin
      #200ms;
      $display("tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
